/* hw/rtl/gmdf_pkg.sv */
`timescale 1ns / 1ps

package gmdf_pkg;

    localparam int MAX_GRID    = 64;
    localparam int MAX_DIST_SQ = 256;
    localparam int COORD_W     = $clog2(MAX_GRID);
    localparam int GRID_W      = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int CELLS       = MAX_GRID * MAX_GRID;
    localparam int DIST_W      = $clog2(MAX_DIST_SQ);
    localparam int RSQ_W       = 9;
    localparam int RISK_W      = 16;
    localparam int POS_W       = 24;
    localparam int CELL_W      = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int SUM_W       = RISK_W + ADDR_W;
    localparam int N_W         = ADDR_W + 1;
    localparam int DIV_W       = 32;
    localparam int WIN_W       = 5;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 64;

    localparam logic [RISK_W-1:0] SRC_MIN = 16'd656;

    localparam logic [GRID_W-1:0] GRID_RESET   = 7'd64;
    localparam logic [CELL_W-1:0] CELL_RESET   = 24'd2560;
    localparam logic [RSQ_W-1:0]  RADIUS_RESET = 9'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_LOAD    = 3'd2,
        CMD_COMPUTE = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_READ,
        ST_READ_DATA,
        ST_CW,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_TGT_RD,
        ST_TGT_MUL,
        ST_TGT_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_BLEND_R,
        ST_DIVR,
        ST_BLEND_S,
        ST_DIVS,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/gmdf_ram.sv */
`timescale 1ns / 1ps

module gmdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/grid_max_decay_field_top.sv */
`timescale 1ns / 1ps
// per item: load weight and unknown commands go straight to the result; read fetches
// both cell maps; add asset runs two divides through the shared restoring divider and
// a max write; clear zeroes both maps; compute sizes w = ceil(sqrt(radius_sq)), seeds,
// spreads strong sources, sums and runs two blend divides; a held result adds its stall
// one item at a time; ready only while the sequencer is idle
// reset: synchronous active low, then a clearing pass over every cell of both cell maps
// during which no beat is taken (config writes are taken at all times)

module grid_max_decay_field_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [gmdf_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [gmdf_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // risk[15:0] pos_x[39:16] pos_y[63:40] cell_col[69:64] cell_row[75:70]
    // weight_index[83:76] weight_value[99:84] zero pad[103:100]
    input  logic [gmdf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]                       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cell_risk[15:0] cell_spread[31:16] global_index[47:32]
    // spread_intensity[63:48]
    output logic [gmdf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import gmdf_pkg::*;

    // config registers
    logic [GRID_W-1:0]  r_grid;
    logic [CELL_W-1:0]  r_cell;
    logic [RSQ_W-1:0]   r_rsq;
    logic [GRID_W-1:0]  g_eff;
    logic [GRID_W-1:0]  g_m1;
    logic [CELL_W-1:0]  cs_eff;
    logic [RSQ_W-1:0]   rsq_eff;

    // input beat fields
    logic [2:0]         in_cmd;
    logic [RISK_W-1:0]  in_risk;
    logic [POS_W-1:0]   in_pos_x;
    logic [POS_W-1:0]   in_pos_y;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [DIST_W-1:0]  in_wi;
    logic [RISK_W-1:0]  in_wv;
    logic               in_accept;

    // sequencer and datapath
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_pend;
    logic [RISK_W-1:0]   r_risk_in;
    logic [POS_W-1:0]    r_pos_y;
    logic                r_rd_ok;
    logic [COORD_W-1:0]  r_x, r_y;
    logic [WIN_W-1:0]    r_w;
    logic [WIN_W:0]      r_dx, r_dy;
    logic [RISK_W-1:0]   r_src;
    logic [RISK_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_taddr;
    logic [N_W-1:0]      r_n;
    logic [SUM_W-1:0]    r_sr, r_sp;
    logic [RISK_W-1:0]   r_mr, r_mp;
    logic [RISK_W-1:0]   r_global, r_intensity;
    logic [RISK_W-1:0]   r_res_risk, r_res_spread;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // shared restoring divider, one quotient bit a cycle
    logic [CELL_W-1:0]   r_div_rem;
    logic [DIV_W-1:0]    r_div_quo;
    logic [CELL_W-1:0]   r_div_den;
    logic [4:0]          r_div_cnt;
    logic [CELL_W:0]     rem_sh;
    logic [CELL_W:0]     rem_diff;
    logic                div_ge;
    logic [DIV_W-1:0]    div_q_next;
    logic                div_last;
    logic [COORD_W-1:0]  q_cell;
    logic [RISK_W-1:0]   q_sat;

    // ram ports
    logic                risk_we, risk_rd_en;
    logic [ADDR_W-1:0]   risk_waddr, risk_raddr;
    logic [RISK_W-1:0]   risk_wdata, risk_rd;
    logic                spr_we, spr_rd_en;
    logic [ADDR_W-1:0]   spr_waddr, spr_raddr;
    logic [RISK_W-1:0]   spr_wdata, spr_rd;
    logic                wt_we, wt_rd_en;
    logic [RISK_W-1:0]   wt_rd;

    // walk helpers
    logic                y_last, x_last, grid_end;
    logic [13:0]         grid_cells;
    logic [9:0]          w_sq;
    logic [WIN_W:0]      w_pos, w_neg;
    logic [7:0]          tx, ty;
    logic [WIN_W-1:0]    adx, ady;
    logic [9:0]          dx_sq, dy_sq, d2;
    logic                tgt_in, tgt_ok, dy_end, win_end;
    logic [31:0]         tgt_mul;
    logic [RISK_W-1:0]   blend_max;
    logic [SUM_W-1:0]    blend_sum;
    logic [28:0]         blend_prod;
    logic [DIV_W-1:0]    blend_num;
    logic [14:0]         blend_den;

    assign in_cmd   = s_axis_tuser;
    assign in_risk  = s_axis_tdata[15:0];
    assign in_pos_x = s_axis_tdata[39:16];
    assign in_pos_y = s_axis_tdata[63:40];
    assign in_col   = s_axis_tdata[69:64];
    assign in_row   = s_axis_tdata[75:70];
    assign in_wi    = s_axis_tdata[83:76];
    assign in_wv    = s_axis_tdata[99:84];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // effective config: grid and cell size 0 act as 1, oversize grid and radius clamp
    always_comb begin
        if (r_grid == '0) begin
            g_eff = 7'd1;
        end else if (r_grid > GRID_W'(MAX_GRID)) begin
            g_eff = GRID_W'(MAX_GRID);
        end else begin
            g_eff = r_grid;
        end
        cs_eff  = (r_cell == '0) ? 24'd1 : r_cell;
        rsq_eff = (r_rsq > RSQ_W'(MAX_DIST_SQ)) ? RSQ_W'(MAX_DIST_SQ) : r_rsq;
    end
    assign g_m1 = g_eff - 7'd1;

    // divider step
    assign rem_sh     = {r_div_rem, r_div_quo[DIV_W-1]};
    assign div_ge     = (rem_sh >= {1'b0, r_div_den});
    assign rem_diff   = rem_sh - {1'b0, r_div_den};
    assign div_q_next = {r_div_quo[DIV_W-2:0], div_ge};
    assign div_last   = (r_div_cnt == 5'd31);
    assign q_cell     = (div_q_next >= {25'd0, g_eff}) ? g_m1[COORD_W-1:0]
                                                       : div_q_next[COORD_W-1:0];
    assign q_sat      = (|div_q_next[DIV_W-1:RISK_W]) ? 16'hFFFF : div_q_next[RISK_W-1:0];

    // raster walk over the grid in use
    assign y_last   = ({1'b0, r_y} + 7'd1) == g_eff;
    assign x_last   = ({1'b0, r_x} + 7'd1) == g_eff;
    assign grid_end = y_last && x_last;
    assign grid_cells = g_eff * g_eff;
    assign w_sq     = r_w * r_w;

    // target window around the current source
    assign w_pos   = {1'b0, r_w};
    assign w_neg   = ~w_pos + 6'd1;
    assign tx      = {2'b00, r_x} + {{2{r_dx[WIN_W]}}, r_dx};
    assign ty      = {2'b00, r_y} + {{2{r_dy[WIN_W]}}, r_dy};
    assign adx     = r_dx[WIN_W] ? 5'(~r_dx + 6'd1) : r_dx[WIN_W-1:0];
    assign ady     = r_dy[WIN_W] ? 5'(~r_dy + 6'd1) : r_dy[WIN_W-1:0];
    assign dx_sq   = adx * adx;
    assign dy_sq   = ady * ady;
    assign d2      = dx_sq + dy_sq;
    assign tgt_in  = !tx[7] && !ty[7] && (tx < {1'b0, g_eff}) && (ty < {1'b0, g_eff});
    assign tgt_ok  = !((r_dx == '0) && (r_dy == '0)) && tgt_in && (d2 < {1'b0, rsq_eff});
    assign dy_end  = (r_dy == w_pos);
    assign win_end = dy_end && (r_dx == w_pos);
    assign tgt_mul = r_src * wt_rd;

    // 0.6 mean + 0.4 max as (3 sum + 2 max n) / (5 n), one multiplier for both maps
    assign blend_max  = (r_state == ST_BLEND_R) ? r_mr : r_mp;
    assign blend_sum  = (r_state == ST_BLEND_R) ? r_sr : r_sp;
    assign blend_prod = blend_max * r_n;
    assign blend_num  = {3'b000, blend_sum, 1'b0} + {4'b0000, blend_sum}
                      + {2'b00, blend_prod, 1'b0};
    assign blend_den  = {r_n, 2'b00} + {2'b00, r_n};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:       if (r_clr_addr == '1) n_state = r_pend ? ST_DONE : ST_IDLE;
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (in_cmd)
                        CMD_CLEAR:   n_state = ST_CLR;
                        CMD_ADD:     n_state = ST_DIVX;
                        CMD_COMPUTE: n_state = ST_CW;
                        CMD_READ:    n_state = ST_READ;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_DIVX:      if (div_last) n_state = ST_DIVY;
            ST_DIVY:      if (div_last) n_state = ST_ADD_RD;
            ST_ADD_RD:    n_state = ST_ADD_WR;
            ST_ADD_WR:    n_state = ST_DONE;
            ST_READ:      n_state = ST_READ_DATA;
            ST_READ_DATA: n_state = ST_DONE;
            ST_CW:        if (w_sq >= {1'b0, rsq_eff}) n_state = ST_SEED_RD;
            ST_SEED_RD:   n_state = ST_SEED_WR;
            ST_SEED_WR:   n_state = grid_end ? ST_SRC_RD : ST_SEED_RD;
            ST_SRC_RD:    n_state = ST_SRC_CHK;
            ST_SRC_CHK: begin
                if (risk_rd >= SRC_MIN) begin
                    n_state = ST_TGT_RD;
                end else begin
                    n_state = grid_end ? ST_SUM_RD : ST_SRC_RD;
                end
            end
            ST_TGT_RD: begin
                if (tgt_ok) begin
                    n_state = ST_TGT_MUL;
                end else if (win_end) begin
                    n_state = grid_end ? ST_SUM_RD : ST_SRC_RD;
                end
            end
            ST_TGT_MUL:   n_state = ST_TGT_WR;
            ST_TGT_WR: begin
                if (win_end) begin
                    n_state = grid_end ? ST_SUM_RD : ST_SRC_RD;
                end else begin
                    n_state = ST_TGT_RD;
                end
            end
            ST_SUM_RD:    n_state = ST_SUM_ACC;
            ST_SUM_ACC:   n_state = grid_end ? ST_BLEND_R : ST_SUM_RD;
            ST_BLEND_R:   n_state = ST_DIVR;
            ST_DIVR:      if (div_last) n_state = ST_BLEND_S;
            ST_BLEND_S:   n_state = ST_DIVS;
            ST_DIVS:      if (div_last) n_state = ST_DONE;
            ST_DONE:      if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        risk_we    = 1'b0;
        risk_waddr = {r_x, r_y};
        risk_wdata = r_risk_in;
        risk_rd_en = 1'b0;
        risk_raddr = {r_x, r_y};
        spr_we     = 1'b0;
        spr_waddr  = {r_x, r_y};
        spr_wdata  = risk_rd;
        spr_rd_en  = 1'b0;
        spr_raddr  = {r_x, r_y};
        wt_we      = in_accept && (in_cmd == CMD_LOAD);
        wt_rd_en   = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                risk_we    = 1'b1;
                risk_waddr = r_clr_addr;
                risk_wdata = '0;
                spr_we     = 1'b1;
                spr_waddr  = r_clr_addr;
                spr_wdata  = '0;
            end
            ST_ADD_RD:  risk_rd_en = 1'b1;
            ST_ADD_WR:  risk_we = (r_risk_in > risk_rd);
            ST_READ: begin
                risk_rd_en = 1'b1;
                spr_rd_en  = 1'b1;
            end
            ST_SEED_RD: risk_rd_en = 1'b1;
            ST_SEED_WR: spr_we = 1'b1;
            ST_SRC_RD:  risk_rd_en = 1'b1;
            ST_TGT_RD: begin
                spr_rd_en = tgt_ok;
                spr_raddr = {tx[COORD_W-1:0], ty[COORD_W-1:0]};
                wt_rd_en  = tgt_ok;
            end
            ST_TGT_WR: begin
                spr_we    = (r_prod > spr_rd);
                spr_waddr = r_taddr;
                spr_wdata = r_prod;
            end
            ST_SUM_RD: begin
                risk_rd_en = 1'b1;
                spr_rd_en  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // config writes, taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_RESET;
            r_cell <= CELL_RESET;
            r_rsq  <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID:   r_grid <= i_cfg_data[GRID_W-1:0];
                CFG_CELL:   r_cell <= i_cfg_data;
                CFG_RADIUS: r_rsq  <= i_cfg_data[RSQ_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_global    <= '0;
            r_intensity <= '0;
        end else begin
            // in the done state the result register is reloaded below
            if (r_out_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR:  r_clr_addr <= r_clr_addr + 12'd1;
                ST_IDLE: begin
                    if (in_accept) begin
                        r_pend     <= 1'b1;
                        r_clr_addr <= '0;
                    end
                end
                ST_DIVR: if (div_last) r_global <= q_sat;
                ST_DIVS: if (div_last) r_intensity <= q_sat;
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_pend      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // last x step reloads the divider for y below
        if (((r_state == ST_DIVX) && !div_last) || (r_state == ST_DIVY) ||
            (r_state == ST_DIVR) || (r_state == ST_DIVS)) begin
            r_div_rem <= div_ge ? rem_diff[CELL_W-1:0] : rem_sh[CELL_W-1:0];
            r_div_quo <= div_q_next;
            r_div_cnt <= r_div_cnt + 5'd1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_res_risk   <= '0;
                    r_res_spread <= '0;
                    r_risk_in    <= in_risk;
                    r_pos_y      <= in_pos_y;
                    r_x          <= in_col;
                    r_y          <= in_row;
                    r_rd_ok      <= ({1'b0, in_col} < g_eff) && ({1'b0, in_row} < g_eff);
                    r_w          <= '0;
                    r_n          <= grid_cells[N_W-1:0];
                    // negative positions truncate to cell zero
                    r_div_rem    <= '0;
                    r_div_quo    <= in_pos_x[POS_W-1] ? '0 : {9'd0, in_pos_x[POS_W-2:0]};
                    r_div_den    <= cs_eff;
                    r_div_cnt    <= '0;
                end
            end
            ST_DIVX: begin
                if (div_last) begin
                    r_x       <= q_cell;
                    r_div_rem <= '0;
                    r_div_quo <= r_pos_y[POS_W-1] ? '0 : {9'd0, r_pos_y[POS_W-2:0]};
                    r_div_cnt <= '0;
                end
            end
            ST_DIVY: if (div_last) r_y <= q_cell;
            ST_READ_DATA: begin
                if (r_rd_ok) begin
                    r_res_risk   <= risk_rd;
                    r_res_spread <= spr_rd;
                end
            end
            ST_CW: begin
                if (w_sq < {1'b0, rsq_eff}) begin
                    r_w <= r_w + 5'd1;
                end else begin
                    r_x <= '0;
                    r_y <= '0;
                end
            end
            ST_SEED_WR, ST_SUM_ACC: begin
                if (r_state == ST_SUM_ACC) begin
                    r_sr <= r_sr + {12'd0, risk_rd};
                    r_sp <= r_sp + {12'd0, spr_rd};
                    if (risk_rd > r_mr) r_mr <= risk_rd;
                    if (spr_rd > r_mp) r_mp <= spr_rd;
                end
                if (y_last) begin
                    r_y <= '0;
                    r_x <= x_last ? '0 : r_x + 6'd1;
                end else begin
                    r_y <= r_y + 6'd1;
                end
                if ((r_state == ST_SEED_WR) && grid_end) begin
                    r_sr <= '0;
                    r_sp <= '0;
                    r_mr <= '0;
                    r_mp <= '0;
                end
            end
            ST_SRC_CHK: begin
                r_src <= risk_rd;
                if (risk_rd >= SRC_MIN) begin
                    r_dx <= w_neg;
                    r_dy <= w_neg;
                end else if (y_last) begin
                    r_y <= '0;
                    r_x <= x_last ? '0 : r_x + 6'd1;
                end else begin
                    r_y <= r_y + 6'd1;
                end
            end
            ST_TGT_RD, ST_TGT_WR: begin
                if ((r_state == ST_TGT_RD) && tgt_ok) begin
                    r_taddr <= {tx[COORD_W-1:0], ty[COORD_W-1:0]};
                end else if (win_end) begin
                    // window done, step to the next source
                    if (y_last) begin
                        r_y <= '0;
                        r_x <= x_last ? '0 : r_x + 6'd1;
                    end else begin
                        r_y <= r_y + 6'd1;
                    end
                end else if (dy_end) begin
                    r_dy <= w_neg;
                    r_dx <= r_dx + 6'd1;
                end else begin
                    r_dy <= r_dy + 6'd1;
                end
            end
            ST_TGT_MUL: r_prod <= tgt_mul[31:16];
            ST_BLEND_R, ST_BLEND_S: begin
                r_div_rem <= '0;
                r_div_quo <= blend_num;
                r_div_den <= {9'd0, blend_den};
                r_div_cnt <= '0;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= {r_intensity, r_global, r_res_spread, r_res_risk};
                end
            end
            default: ;
        endcase
    end

    gmdf_ram #(.WIDTH(RISK_W), .DEPTH(CELLS)) u_risk_ram (
        .i_clk     (i_clk),
        .i_we      (risk_we),
        .i_wr_addr (risk_waddr),
        .i_wr_data (risk_wdata),
        .i_rd_en   (risk_rd_en),
        .i_rd_addr (risk_raddr),
        .o_rd_data (risk_rd)
    );

    gmdf_ram #(.WIDTH(RISK_W), .DEPTH(CELLS)) u_spread_ram (
        .i_clk     (i_clk),
        .i_we      (spr_we),
        .i_wr_addr (spr_waddr),
        .i_wr_data (spr_wdata),
        .i_rd_en   (spr_rd_en),
        .i_rd_addr (spr_raddr),
        .o_rd_data (spr_rd)
    );

    gmdf_ram #(.WIDTH(RISK_W), .DEPTH(MAX_DIST_SQ)) u_weight_ram (
        .i_clk     (i_clk),
        .i_we      (wt_we),
        .i_wr_addr (in_wi),
        .i_wr_data (in_wv),
        .i_rd_en   (wt_rd_en),
        .i_rd_addr (d2[DIST_W-1:0]),
        .o_rd_data (wt_rd)
    );

    // one beat in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("new beat taken while busy");

    // spread writes stay inside the grid in use
    a_tgt_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TGT_WR) |->
            (({1'b0, r_taddr[ADDR_W-1:COORD_W]} < g_eff) &&
             ({1'b0, r_taddr[COORD_W-1:0]} < g_eff)))
        else $error("spread target outside grid");

    // weight lookups only below the radius
    a_weight_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TGT_MUL) |-> ($past(d2) < {1'b0, rsq_eff}))
        else $error("weight index beyond radius");

endmodule
